### hw/rtl/pmlc_pkg.sv
// Shared types and constants for the pump mode and level controller.
package pmlc_pkg;

  localparam int unsigned DEBOUNCE_W     = 20;
  localparam int unsigned COUNT_BITS_DEF = 20;
  localparam int unsigned ADDR_W         = 3;
  localparam int unsigned DATA_W         = 32;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(60 * 1000);

  // register index, taken from paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_DEBOUNCE_MS = '0;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_AUTO = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    LVL_UNKNOWN = 2'd0,
    LVL_OK      = 2'd1,
    LVL_LOW     = 2'd2
  } lvl_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_LOW  = 2'd1,
    EV_OK   = 2'd2
  } ev_t;

  typedef enum logic [1:0] {
    LED_SHORT_ON = 2'd0,
    LED_LONG_ON  = 2'd1,
    LED_EVEN     = 2'd2
  } led_t;

  typedef struct packed {
    ev_t  ev;
    lvl_t state;
    logic load;
  } qual_res_t;

endpackage

### hw/rtl/pmlc_if.sv
// Request channel interfaces: tick requests in, status results out.
interface pmlc_tick_if;
  logic       valid;
  logic       ready;
  logic       level_open;
  logic       short_press;
  logic       mode_set_valid;
  logic [1:0] mode_set_value;

  modport source(output valid, level_open, short_press, mode_set_valid, mode_set_value,
                 input ready);
  modport sink(input valid, level_open, short_press, mode_set_valid, mode_set_value,
               output ready);
endinterface

interface pmlc_status_if;
  logic       valid;
  logic       ready;
  logic       pump_on;
  logic [1:0] mode_now;
  logic [1:0] level_event;
  logic [1:0] led_pattern;

  modport source(output valid, pump_on, mode_now, level_event, led_pattern, input ready);
  modport sink(input valid, pump_on, mode_now, level_event, led_pattern, output ready);
endinterface

### hw/rtl/pmlc_qual.sv
// Level qualifier: unknown/ok/low tracking with lockout gating.
module pmlc_qual
  import pmlc_pkg::*;
(
  input  logic      run,
  input  lvl_t      state,
  input  logic      done,
  input  logic      low,
  output qual_res_t res
);

  always_comb begin
    res.ev    = EV_NONE;
    res.state = state;
    res.load  = 1'b0;
    if (run) begin
      case (state)
        LVL_UNKNOWN: begin
          if (low) begin
            res.ev    = EV_LOW;
            res.state = LVL_LOW;
            res.load  = 1'b1;
          end else begin
            res.ev    = EV_OK;
            res.state = LVL_OK;
          end
        end
        LVL_OK: begin
          if (done && low) begin
            res.ev    = EV_LOW;
            res.state = LVL_LOW;
            res.load  = 1'b1;
          end
        end
        LVL_LOW: begin
          if (done && !low) begin
            res.ev    = EV_OK;
            res.state = LVL_OK;
            res.load  = 1'b1;
          end
        end
        default: begin
          res.ev = EV_NONE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/pump_mode_level_controller_top.sv
// Top level of the pump mode and level controller.
// A request is held in the input register, then its result in the result register.
// Throughput: one tick request per cycle; a stalled result holds the input stage.
// Reset (rst, synchronous): mode auto, pump off, level unknown, lockout expired,
// debounce_ms = 60000, both pipeline stages empty.
module pump_mode_level_controller_top
  import pmlc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  pmlc_tick_if.sink         tick,
  pmlc_status_if.source     status
);

  logic [DEBOUNCE_W-1:0] debounce_ms;
  logic                  cfg_sel;

  mode_t                 mode_reg;
  logic                  pump_reg;
  lvl_t                  level_state;
  logic [COUNT_BITS-1:0] lockout_count;

  logic       s1_valid;
  logic       s1_level_open;
  logic       s1_short_press;
  logic       s1_mode_set_valid;
  logic [1:0] s1_mode_set_value;

  logic out_free;
  logic commit;

  logic [COUNT_BITS-1:0] cnt_dec;
  logic [COUNT_BITS-1:0] load_val;
  logic [COUNT_BITS-1:0] lockout_count_next;
  qual_res_t             q;
  mode_t                 mode_reg_next;
  logic                  pump_reg_next;
  led_t                  led_next;

  // configuration
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[ADDR_W-1:2] == REG_DEBOUNCE_MS);

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms <= DEBOUNCE_RESET;
    end else if (psel && penable && pwrite && cfg_sel) begin
      debounce_ms <= pwdata[DEBOUNCE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (cfg_sel) begin
      prdata = DATA_W'(debounce_ms);
    end
  end

  // pipeline control
  assign out_free   = !status.valid || status.ready;
  assign commit     = s1_valid && out_free;
  assign tick.ready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      status.valid <= 1'b0;
    end else begin
      if (tick.valid && tick.ready) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        status.valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_level_open     <= tick.level_open;
      s1_short_press    <= tick.short_press;
      s1_mode_set_valid <= tick.mode_set_valid;
      s1_mode_set_value <= tick.mode_set_value;
    end
  end

  // lockout counter
  generate
    if (COUNT_BITS >= DEBOUNCE_W) begin : g_load_wide
      assign load_val = COUNT_BITS'(debounce_ms);
    end else begin : g_load_sat
      assign load_val = (|debounce_ms[DEBOUNCE_W-1:COUNT_BITS]) ? '1 :
                        debounce_ms[COUNT_BITS-1:0];
    end
  endgenerate

  assign cnt_dec = (lockout_count != '0) ? lockout_count - 1'b1 : lockout_count;

  pmlc_qual u_qual (
    .run  (mode_reg == MODE_AUTO),
    .state(level_state),
    .done (cnt_dec == '0),
    .low  (s1_level_open),
    .res  (q)
  );

  assign lockout_count_next = q.load ? load_val : cnt_dec;

  // mode and pump update: level, then button, then remote command
  always_comb begin
    mode_reg_next = mode_reg;
    pump_reg_next = pump_reg;
    if (q.ev == EV_LOW) begin
      pump_reg_next = 1'b0;
    end else if (q.ev == EV_OK) begin
      pump_reg_next = 1'b1;
    end
    if (s1_short_press) begin
      case (mode_reg)
        MODE_OFF: begin
          mode_reg_next = MODE_ON;
          pump_reg_next = 1'b1;
        end
        MODE_ON: begin
          mode_reg_next = MODE_AUTO;
        end
        MODE_AUTO: begin
          mode_reg_next = MODE_OFF;
          pump_reg_next = 1'b0;
        end
        default: begin
          mode_reg_next = mode_reg;
        end
      endcase
    end
    if (s1_mode_set_valid) begin
      if (s1_mode_set_value == MODE_OFF) begin
        mode_reg_next = MODE_OFF;
        pump_reg_next = 1'b0;
      end else if (s1_mode_set_value == MODE_ON) begin
        mode_reg_next = MODE_ON;
        pump_reg_next = 1'b1;
      end else if (s1_mode_set_value == MODE_AUTO) begin
        mode_reg_next = MODE_AUTO;
      end
    end
  end

  always_comb begin
    case (mode_reg_next)
      MODE_OFF:  led_next = LED_SHORT_ON;
      MODE_ON:   led_next = LED_LONG_ON;
      MODE_AUTO: led_next = LED_EVEN;
      default:   led_next = LED_EVEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_AUTO;
      pump_reg      <= 1'b0;
      level_state   <= LVL_UNKNOWN;
      lockout_count <= '0;
    end else if (commit) begin
      mode_reg      <= mode_reg_next;
      pump_reg      <= pump_reg_next;
      level_state   <= q.state;
      lockout_count <= lockout_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status.pump_on     <= pump_reg_next;
      status.mode_now    <= mode_reg_next;
      status.level_event <= q.ev;
      status.led_pattern <= led_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_value: assert property (@(posedge clk) disable iff (rst)
    commit && q.load |=> lockout_count == $past(load_val))
    else $error("lockout load mismatch");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    commit && !q.load && lockout_count != '0 |=> lockout_count == $past(lockout_count) - 1'b1)
    else $error("lockout countdown mismatch");

  a_event_auto_only: assert property (@(posedge clk) disable iff (rst)
    commit && mode_reg != MODE_AUTO |-> q.ev == EV_NONE)
    else $error("level event outside auto mode");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_level_open))
    else $error("input stage dropped a request");
`endif

endmodule

### verif/tb_pump_mode_level_controller_top.sv
// Testbench for the pump mode and level controller: directed and random tick requests against a predictor.
`timescale 1ns / 1ps

module tb_pump_mode_level_controller_top;
  import pmlc_pkg::*;

  localparam logic [1:0] CMD_IGNORED = 2'd3;
  localparam logic [ADDR_W-1:0] DEBOUNCE_ADDR = {REG_DEBOUNCE_MS, 2'b00};
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MAX = '1;

  typedef struct packed {
    logic       level_open;
    logic       short_press;
    logic       mode_set_valid;
    logic [1:0] mode_set_value;
  } tick_t;

  typedef struct packed {
    logic  pump_on;
    mode_t mode_now;
    ev_t   level_event;
    led_t  led_pattern;
  } pump_status_t;

  class pump_status_board;
    mode_t                 mode;
    logic                  pump;
    lvl_t                  lvl;
    logic [DEBOUNCE_W-1:0] lockout;
    logic [DEBOUNCE_W-1:0] debounce;
    pump_status_t          pending[$];
    int                    errors;
    int                    results;
    int                    lows;
    int                    oks;

    function new();
      mode     = MODE_AUTO;
      pump     = 1'b0;
      lvl      = LVL_UNKNOWN;
      lockout  = '0;
      debounce = DEBOUNCE_RESET;
      errors   = 0;
      results  = 0;
      lows     = 0;
      oks      = 0;
    endfunction

    function void set_mode(logic [1:0] m);
      case (m)
        MODE_OFF: begin
          mode = MODE_OFF;
          pump = 1'b0;
        end
        MODE_ON: begin
          mode = MODE_ON;
          pump = 1'b1;
        end
        MODE_AUTO: mode = MODE_AUTO;
        default: ;
      endcase
    endfunction

    function ev_t qualify(logic low);
      logic expired;
      expired = (lockout == '0);
      if (lvl == LVL_UNKNOWN) begin
        if (low) begin
          lvl = LVL_LOW;
          lockout = debounce;
          return EV_LOW;
        end
        lvl = LVL_OK;
        return EV_OK;
      end
      if (lvl == LVL_OK && expired && low) begin
        lvl = LVL_LOW;
        lockout = debounce;
        return EV_LOW;
      end
      if (lvl == LVL_LOW && expired && !low) begin
        lvl = LVL_OK;
        lockout = debounce;
        return EV_OK;
      end
      return EV_NONE;
    endfunction

    function void note_tick(tick_t t);
      pump_status_t s;
      s.level_event = EV_NONE;
      if (lockout != '0) lockout = lockout - 1'b1;
      if (mode == MODE_AUTO) begin
        s.level_event = qualify(t.level_open);
        if (s.level_event == EV_LOW) begin
          pump = 1'b0;
          lows++;
        end else if (s.level_event == EV_OK) begin
          pump = 1'b1;
          oks++;
        end
      end
      if (t.short_press) begin
        case (mode)
          MODE_OFF:  set_mode(MODE_ON);
          MODE_ON:   set_mode(MODE_AUTO);
          MODE_AUTO: set_mode(MODE_OFF);
          default: ;
        endcase
      end
      if (t.mode_set_valid) set_mode(t.mode_set_value);
      s.pump_on  = pump;
      s.mode_now = mode;
      case (mode)
        MODE_OFF: s.led_pattern = LED_SHORT_ON;
        MODE_ON:  s.led_pattern = LED_LONG_ON;
        default:  s.led_pattern = LED_EVEN;
      endcase
      pending.push_back(s);
    endfunction

    function void check_status(logic pump_on, logic [1:0] mode_now, logic [1:0] level_event,
                               logic [1:0] led_pattern);
      pump_status_t e;
      results++;
      if (pending.size() == 0) begin
        $error("status result with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (pump_on !== e.pump_on) begin
        $error("pump_on: expected %0d, got %0d", e.pump_on, pump_on);
        errors++;
      end
      if (mode_now !== e.mode_now) begin
        $error("mode_now: expected %0d, got %0d", e.mode_now, mode_now);
        errors++;
      end
      if (level_event !== e.level_event) begin
        $error("level_event: expected %0d, got %0d", e.level_event, level_event);
        errors++;
      end
      if (led_pattern !== e.led_pattern) begin
        $error("led_pattern: expected %0d, got %0d", e.led_pattern, led_pattern);
        errors++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                stall_pct;
  int                settings;
  pump_status_board  board;

  pmlc_tick_if   tick_ch();
  pmlc_status_if status_ch();

  pump_mode_level_controller_top dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .tick   (tick_ch),
    .status (status_ch)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      status_ch.ready <= 1'b0;
    end else begin
      if (status_ch.valid && status_ch.ready) begin
        board.check_status(status_ch.pump_on, status_ch.mode_now, status_ch.level_event,
                           status_ch.led_pattern);
      end
      status_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
    logic [DATA_W-1:0] back;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DEBOUNCE_ADDR;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    board.debounce = value;
    settings++;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back[DEBOUNCE_W-1:0] !== value) begin
      $error("debounce_ms: expected %0d, got %0d", value, back[DEBOUNCE_W-1:0]);
      board.errors++;
    end
  endtask

  task automatic send_tick(input logic lvl, input logic btn, input logic cmd,
                           input logic [1:0] cmd_mode);
    tick_t t;
    t = {lvl, btn, cmd, cmd_mode};
    tick_ch.valid          <= 1'b1;
    tick_ch.level_open     <= lvl;
    tick_ch.short_press    <= btn;
    tick_ch.mode_set_valid <= cmd;
    tick_ch.mode_set_value <= cmd_mode;
    do @(posedge clk); while (!tick_ch.ready);
    board.note_tick(t);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (board.pending.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int idle_pct, input int stall_in);
    logic       lvl;
    logic       sample;
    logic       cmd;
    logic [1:0] cmd_mode;
    stall_pct = stall_in;
    lvl = 1'($urandom_range(1));
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(99) < idle_pct) begin
        tick_ch.valid <= 1'b0;
        @(posedge clk);
      end
      // sticky level with occasional flips and one-tick glitches
      if ($urandom_range(99) < 8) lvl = ~lvl;
      sample = ($urandom_range(99) < 15) ? 1'($urandom_range(1)) : lvl;
      cmd = ($urandom_range(99) < 6);
      cmd_mode = ($urandom_range(1) == 1) ? MODE_AUTO : 2'($urandom_range(3));
      if (!cmd && $urandom_range(1) == 1) cmd_mode = 2'($urandom_range(3));
      send_tick(sample, $urandom_range(99) < 4, cmd, cmd_mode);
    end
    tick_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [DEBOUNCE_W-1:0] deb[8];
    int idle_tab[4];
    int stall_tab[4];
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_ch.valid = 1'b0;
    tick_ch.level_open = 1'b0;
    tick_ch.short_press = 1'b0;
    tick_ch.mode_set_valid = 1'b0;
    tick_ch.mode_set_value = MODE_OFF;
    status_ch.ready = 1'b0;
    stall_pct = 0;
    settings = 0;
    board = new();
    idle_tab = '{0, 69, 0, 13};
    stall_tab = '{0, 0, 69, 13};
    // longest lockout last so it does not mute level events in later phases
    deb = '{'0, DEBOUNCE_W'(1), DEBOUNCE_W'(2 + $urandom_range(30)), DEBOUNCE_W'(5),
            DEBOUNCE_W'($urandom_range(12)), DEBOUNCE_W'(2), DEBOUNCE_W'($urandom_range(40)),
            DEBOUNCE_MAX};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_debounce(DEBOUNCE_W'(3));

    // first sample low, lockout, button cycle, commands incl. ignored and re-set
    send_tick(1'b1, 1'b0, 1'b0, MODE_OFF);
    send_tick(1'b0, 1'b0, 1'b0, MODE_OFF);
    send_tick(1'b0, 1'b0, 1'b0, MODE_OFF);
    send_tick(1'b0, 1'b0, 1'b0, MODE_OFF);
    send_tick(1'b1, 1'b0, 1'b0, MODE_OFF);
    send_tick(1'b1, 1'b0, 1'b0, MODE_OFF);
    send_tick(1'b1, 1'b0, 1'b0, MODE_OFF);
    send_tick(1'b1, 1'b1, 1'b0, MODE_OFF);
    send_tick(1'b0, 1'b1, 1'b0, MODE_OFF);
    send_tick(1'b0, 1'b0, 1'b1, MODE_ON);
    send_tick(1'b1, 1'b1, 1'b0, MODE_OFF);
    send_tick(1'b1, 1'b0, 1'b1, CMD_IGNORED);
    send_tick(1'b0, 1'b0, 1'b1, MODE_OFF);
    send_tick(1'b0, 1'b0, 1'b1, MODE_OFF);
    send_tick(1'b0, 1'b1, 1'b1, MODE_AUTO);
    send_tick(1'b1, 1'b0, 1'b1, MODE_AUTO);
    send_tick(1'b0, 1'b0, 1'b0, MODE_OFF);
    send_tick(1'b1, 1'b1, 1'b1, MODE_ON);
    send_tick(1'b1, 1'b0, 1'b1, MODE_AUTO);
    send_tick(1'b0, 1'b0, 1'b0, CMD_IGNORED);
    send_tick(1'b1, 1'b1, 1'b1, CMD_IGNORED);
    tick_ch.valid <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      drain();
      write_debounce(deb[p]);
      run_phase(185, idle_tab[p % 4], stall_tab[p % 4]);
    end
    drain();
    if (board.pending.size() != 0) begin
      $error("%0d status results never arrived", board.pending.size());
      board.errors++;
    end

    $display("run: %0d status results checked over %0d debounce settings",
             board.results, settings);
    $display("run: %0d low and %0d ok level events seen", board.lows, board.oks);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
hw/rtl/pmlc_pkg.sv
hw/rtl/pmlc_if.sv
hw/rtl/pmlc_qual.sv
hw/rtl/pump_mode_level_controller_top.sv
verif/tb_pump_mode_level_controller_top.sv
